FILE: rtl/core/tprt_pkg.sv
`default_nettype none

package tprt_pkg;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    // Kind codes of a result item.
    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_REALTIME_ENABLE = 1'b0;
    localparam logic CFG_SPEED_FACTOR    = 1'b1;

    localparam int unsigned TIME_W  = 40;
    localparam int unsigned SPEED_W = 15;
    localparam int unsigned OCC_W   = 7;

    localparam logic [TIME_W-1:0]  TIME_MAX    = {TIME_W{1'b1}};
    localparam logic [SPEED_W-1:0] SPEED_MIN   = 15'd13;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 15'd16384;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 15'd256;

    // The scaled delay is a 40-bit dividend retired two quotient bits per cycle.
    localparam int unsigned DIV_BITS_PER_CYCLE = 2;
    localparam int unsigned DIV_STEPS          = TIME_W / DIV_BITS_PER_CYCLE;
    localparam int unsigned DIV_CNT_W          = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [TIME_W-1:0] release_time;
        logic [7:0]        receiver;
        logic [15:0]       handle;
        logic [11:0]       length;
    } t_slot;

    localparam int unsigned SLOT_DATA_W = $bits(t_slot);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DIV      = 7'b0000010,
        S_ENQ      = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_EMIT_RD  = 7'b0010000,
        S_EMIT_OUT = 7'b0100000,
        S_REPLY    = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/tprt_ram.sv
`default_nettype none

module tprt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/timed_packet_release_table_core.sv
// Timed packet release table.
// Input channel (i_in_valid / o_in_ready) carries one command per transfer:
// enqueue a packet, tick the clock, or clear the table. Output channel
// (o_out_valid / i_out_ready) returns result items; the final one of a command
// has o_last set, and every result reports the occupancy after it.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data): index 0
// enables enqueueing, index 1 sets the speed factor in units of 1/256.
// One command is handled at a time; o_in_ready is high only while idle.
// Slot contents live in one RAM with a registered read.
// Enqueue: a radix-4 divider scales the delay, then the slot is written and the
// reply follows. Rejected enqueue, clear and unknown codes go straight to the
// reply. Tick: a pipelined RAM scan, then for each released slot a RAM read and
// then an output load, or one acknowledge.
// The output register holds a result until it is taken; while the receiver
// stalls, the sequencer waits before loading the next result and nothing is lost.
// Reset (synchronous, active low) empties the table, disables enqueueing and
// sets the speed factor to 256. No clearing pass is needed after reset.
`default_nettype none

module timed_packet_release_table_core #(
    parameter int unsigned SLOTS       = 16,
    parameter int unsigned PAYLOAD_MAX = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [14:0] i_cfg_data,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [39:0] i_now_us,
    input  wire logic signed [31:0] i_delay_us,
    input  wire logic [7:0]  i_receiver_id,
    input  wire logic [15:0] i_packet_handle,
    input  wire logic [11:0] i_length,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic             o_accepted,
    output logic [7:0]       o_out_receiver,
    output logic [15:0]      o_out_handle,
    output logic [11:0]      o_out_length,
    output logic [6:0]       o_occupancy,
    output logic             o_last
);

    localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
    localparam int unsigned TW     = tprt_pkg::TIME_W;
    localparam int unsigned SW     = tprt_pkg::SPEED_W;

    // Control state.
    tprt_pkg::t_state r_state, n_state;
    logic              r_rt_en, n_rt_en;
    logic [SW-1:0]     r_speed, n_speed;
    logic [SLOTS-1:0]  r_active, n_active;
    logic [SLOTS-1:0]  r_due, n_due;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;
    logic              r_issue, n_issue;
    logic              r_rd_vld, n_rd_vld;

    // Datapath registers.
    logic [TW-1:0]     r_now, n_now;
    logic [7:0]        r_rcv, n_rcv;
    logic [15:0]       r_hnd, n_hnd;
    logic [11:0]       r_len, n_len;
    logic [SW-1:0]     r_div, n_div;
    logic [SW-1:0]     r_rem, n_rem;
    logic [TW-1:0]     r_dq, n_dq;
    logic [tprt_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [SLOT_W-1:0] r_scan_idx, n_scan_idx;
    logic [SLOT_W-1:0] r_rd_idx, n_rd_idx;
    logic [SLOT_W-1:0] r_emit_idx, n_emit_idx;
    logic [1:0]        r_rep_kind, n_rep_kind;
    logic              r_rep_acc, n_rep_acc;
    logic [1:0]        r_o_kind, n_o_kind;
    logic              r_o_acc, n_o_acc;
    logic [7:0]        r_o_rcv, n_o_rcv;
    logic [15:0]       r_o_hnd, n_o_hnd;
    logic [11:0]       r_o_len, n_o_len;
    logic [CNT_W-1:0]  r_o_occ, n_o_occ;
    logic              r_o_last, n_o_last;

    // RAM port signals.
    logic                 w_we, w_re;
    logic [SLOT_W-1:0]    w_waddr, w_raddr;
    tprt_pkg::t_slot      w_wslot, w_rslot;
    logic [tprt_pkg::SLOT_DATA_W-1:0] w_rdata;

    logic              w_out_free;
    logic [SLOT_W-1:0] w_free_idx, w_due_idx;
    logic [SW-1:0]     w_div_rem;
    logic [TW-1:0]     w_div_dq;
    logic [TW:0]       w_rel_sum;
    logic [TW-1:0]     w_rel;
    logic [SW-1:0]     w_speed_clamped;
    logic              w_len_ok;

    tprt_ram #(
        .WIDTH (tprt_pkg::SLOT_DATA_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wslot),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rslot = tprt_pkg::t_slot'(w_rdata);

    // Lowest free slot and lowest due slot.
    always_comb begin
        w_free_idx = '0;
        w_due_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_idx = SLOT_W'(i);
            end
            if (r_due[i]) begin
                w_due_idx = SLOT_W'(i);
            end
        end
    end

    // Two restoring division steps per cycle.
    always_comb begin
        logic [SW:0] t;
        logic [SW-1:0] rem;
        logic [TW-1:0] dq;
        rem = r_rem;
        dq  = r_dq;
        for (int k = 0; k < int'(tprt_pkg::DIV_BITS_PER_CYCLE); k++) begin
            t  = {rem, dq[TW-1]};
            dq = {dq[TW-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                rem   = SW'(t - {1'b0, r_div});
                dq[0] = 1'b1;
            end else begin
                rem = t[SW-1:0];
            end
        end
        w_div_rem = rem;
        w_div_dq  = dq;
    end

    // After the last step r_dq holds the quotient; a carry out means saturation.
    assign w_rel_sum = {1'b0, r_now} + {1'b0, r_dq};
    assign w_rel     = w_rel_sum[TW] ? tprt_pkg::TIME_MAX : w_rel_sum[TW-1:0];

    always_comb begin
        if (r_speed < tprt_pkg::SPEED_MIN) begin
            w_speed_clamped = tprt_pkg::SPEED_MIN;
        end else if (r_speed > tprt_pkg::SPEED_MAX) begin
            w_speed_clamped = tprt_pkg::SPEED_MAX;
        end else begin
            w_speed_clamped = r_speed;
        end
    end

    assign w_len_ok   = (i_length != 12'd0) && (i_length <= 12'(PAYLOAD_MAX));
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_wslot.release_time = w_rel;
    assign w_wslot.receiver     = r_rcv;
    assign w_wslot.handle       = r_hnd;
    assign w_wslot.length       = r_len;
    assign w_waddr              = w_free_idx;

    always_comb begin
        n_state     = r_state;
        n_rt_en     = r_rt_en;
        n_speed     = r_speed;
        n_active    = r_active;
        n_due       = r_due;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_issue     = r_issue;
        n_rd_vld    = 1'b0;
        n_now       = r_now;
        n_rcv       = r_rcv;
        n_hnd       = r_hnd;
        n_len       = r_len;
        n_div       = r_div;
        n_rem       = r_rem;
        n_dq        = r_dq;
        n_div_cnt   = r_div_cnt;
        n_scan_idx  = r_scan_idx;
        n_rd_idx    = r_rd_idx;
        n_emit_idx  = r_emit_idx;
        n_rep_kind  = r_rep_kind;
        n_rep_acc   = r_rep_acc;
        n_o_kind    = r_o_kind;
        n_o_acc     = r_o_acc;
        n_o_rcv     = r_o_rcv;
        n_o_hnd     = r_o_hnd;
        n_o_len     = r_o_len;
        n_o_occ     = r_o_occ;
        n_o_last    = r_o_last;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_raddr     = r_scan_idx;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tprt_pkg::CFG_REALTIME_ENABLE: n_rt_en = i_cfg_data[0];
                tprt_pkg::CFG_SPEED_FACTOR:    n_speed = i_cfg_data;
                default:                       n_speed = r_speed;
            endcase
        end

        unique case (r_state)
            tprt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_now = i_now_us;
                    n_rcv = i_receiver_id;
                    n_hnd = i_packet_handle;
                    n_len = i_length;
                    n_rep_kind = tprt_pkg::KIND_ACK;
                    n_rep_acc  = 1'b0;
                    priority if (i_func == tprt_pkg::FUNC_ENQUEUE) begin
                        n_rep_kind = tprt_pkg::KIND_REPLY;
                        if (r_rt_en && w_len_ok && (r_count != CNT_W'(SLOTS))) begin
                            n_div     = w_speed_clamped;
                            n_rem     = '0;
                            // Negative delays count as zero; the dividend is delay * 256.
                            n_dq      = i_delay_us[31] ? '0 : {1'b0, i_delay_us[30:0], 8'd0};
                            n_div_cnt = '0;
                            n_state   = tprt_pkg::S_DIV;
                        end else begin
                            n_state = tprt_pkg::S_REPLY;
                        end
                    end else if (i_func == tprt_pkg::FUNC_TICK) begin
                        n_due      = '0;
                        n_issue    = 1'b1;
                        n_scan_idx = '0;
                        n_state    = tprt_pkg::S_SCAN;
                    end else if (i_func == tprt_pkg::FUNC_CLEAR) begin
                        n_active = '0;
                        n_count  = '0;
                        n_state  = tprt_pkg::S_REPLY;
                    end else begin
                        n_state = tprt_pkg::S_REPLY;
                    end
                end
            end

            tprt_pkg::S_DIV: begin
                n_rem     = w_div_rem;
                n_dq      = w_div_dq;
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == tprt_pkg::DIV_CNT_W'(tprt_pkg::DIV_STEPS - 1)) begin
                    n_state = tprt_pkg::S_ENQ;
                end
            end

            tprt_pkg::S_ENQ: begin
                w_we                 = 1'b1;
                n_active[w_free_idx] = 1'b1;
                n_count              = r_count + 1'b1;
                n_rep_acc            = 1'b1;
                n_state              = tprt_pkg::S_REPLY;
            end

            tprt_pkg::S_SCAN: begin
                // Reads are issued back to back; each compare lands in the cycle after its read.
                if (r_issue) begin
                    w_re     = 1'b1;
                    w_raddr  = r_scan_idx;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_scan_idx;
                    if (r_scan_idx == SLOT_W'(SLOTS - 1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_scan_idx = r_scan_idx + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    n_due[r_rd_idx] = r_active[r_rd_idx] && (w_rslot.release_time <= r_now);
                    if (r_rd_idx == SLOT_W'(SLOTS - 1)) begin
                        n_state = (n_due == '0) ? tprt_pkg::S_REPLY : tprt_pkg::S_EMIT_RD;
                    end
                end
            end

            tprt_pkg::S_EMIT_RD: begin
                w_re       = 1'b1;
                w_raddr    = w_due_idx;
                n_emit_idx = w_due_idx;
                n_state    = tprt_pkg::S_EMIT_OUT;
            end

            tprt_pkg::S_EMIT_OUT: begin
                if (w_out_free) begin
                    n_due[r_emit_idx]    = 1'b0;
                    n_active[r_emit_idx] = 1'b0;
                    n_count     = r_count - 1'b1;
                    n_out_valid = 1'b1;
                    n_o_kind    = tprt_pkg::KIND_DELIVER;
                    n_o_acc     = 1'b0;
                    n_o_rcv     = w_rslot.receiver;
                    n_o_hnd     = w_rslot.handle;
                    n_o_len     = w_rslot.length;
                    n_o_occ     = r_count - 1'b1;
                    n_o_last    = (n_due == '0);
                    n_state     = (n_due == '0) ? tprt_pkg::S_IDLE : tprt_pkg::S_EMIT_RD;
                end
            end

            tprt_pkg::S_REPLY: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = r_rep_kind;
                    n_o_acc     = r_rep_acc;
                    n_o_rcv     = '0;
                    n_o_hnd     = '0;
                    n_o_len     = '0;
                    n_o_occ     = r_count;
                    n_o_last    = 1'b1;
                    n_state     = tprt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tprt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tprt_pkg::S_IDLE;
            r_rt_en     <= 1'b0;
            r_speed     <= tprt_pkg::SPEED_RESET;
            r_active    <= '0;
            r_due       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rt_en     <= n_rt_en;
            r_speed     <= n_speed;
            r_active    <= n_active;
            r_due       <= n_due;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_issue     <= n_issue;
            r_rd_vld    <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_rcv      <= n_rcv;
        r_hnd      <= n_hnd;
        r_len      <= n_len;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_dq       <= n_dq;
        r_div_cnt  <= n_div_cnt;
        r_scan_idx <= n_scan_idx;
        r_rd_idx   <= n_rd_idx;
        r_emit_idx <= n_emit_idx;
        r_rep_kind <= n_rep_kind;
        r_rep_acc  <= n_rep_acc;
        r_o_kind   <= n_o_kind;
        r_o_acc    <= n_o_acc;
        r_o_rcv    <= n_o_rcv;
        r_o_hnd    <= n_o_hnd;
        r_o_len    <= n_o_len;
        r_o_occ    <= n_o_occ;
        r_o_last   <= n_o_last;
    end

    assign o_in_ready     = (r_state == tprt_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_o_kind;
    assign o_accepted     = r_o_acc;
    assign o_out_receiver = r_o_rcv;
    assign o_out_handle   = r_o_hnd;
    assign o_out_length   = r_o_len;
    assign o_occupancy    = tprt_pkg::OCC_W'(r_o_occ);
    assign o_last         = r_o_last;

`ifndef SYNTHESIS
    a_count_matches_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_active) == int'(r_count))
        else $error("occupancy count disagrees with active slot bits");

    a_due_subset_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tprt_pkg::S_EMIT_RD || r_state == tprt_pkg::S_EMIT_OUT)
        |-> ((r_due & ~r_active) == '0))
        else $error("a due slot is not active");

    a_emit_slot_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tprt_pkg::S_EMIT_OUT) |-> (r_due[r_emit_idx] && r_active[r_emit_idx]))
        else $error("delivering a slot that is not due");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tprt_pkg::S_DIV) |-> (r_rem < r_div))
        else $error("divider remainder out of range");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tprt_pkg::S_ENQ) |=> (r_count == $past(r_count) + 1'b1))
        else $error("enqueue write did not take a slot");
`endif

endmodule

`default_nettype wire
